[hw/rtl/adlr_pkg.sv]
// ----------------------------------------------------------------------------
// adlr_pkg
// Shared widths, register indexes and the result type of the downmix
// resampler.
// ----------------------------------------------------------------------------
package adlr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int NCH_W       = 4;
    localparam int STEP_CFG_W  = 20;
    localparam int CLEN_W      = 13;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LENGTH = 2'd2;

    localparam logic [NCH_W-1:0]  NCH_RESET  = 4'd1;
    localparam logic [CLEN_W-1:0] CLEN_RESET = 13'd320;

    // outputs made for one mono sample at most
    localparam int MAX_OUT   = 16;
    localparam int OUT_CNT_W = 5;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] value;
        logic                chunk_end;
    } result_t;

endpackage

[hw/rtl/adlr_fifo.sv]
// ----------------------------------------------------------------------------
// adlr_fifo
// Small register FIFO with the head shown combinationally.
// ----------------------------------------------------------------------------
module adlr_fifo
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/adlr_front.sv]
// ----------------------------------------------------------------------------
// adlr_front
// Takes interleaved channel samples, sums each frame and divides by the
// channel count (truncating towards zero) with a bit-serial divider.
// ----------------------------------------------------------------------------
module adlr_front
    import adlr_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [NCH_W-1:0]           num_channels,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] capture_sample,
    output logic                       mono_push,
    input  logic                       mono_full,
    output logic [SAMPLE_W-1:0]        mono_value
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int DIV_W = $clog2(MAX_CHANNELS + 1);
    localparam int BIT_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0]
    {
        F_TAKE = 3'b001,
        F_DIV  = 3'b010,
        F_HOLD = 3'b100
    } front_state_t;

    front_state_t            state_reg, state_next;
    logic [CH_W-1:0]         pos_reg, pos_next;
    logic signed [SUM_W-1:0] frame_sum_reg, frame_sum_next;
    logic [BIT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic                    sign_reg, sign_next;

    logic [DIV_W-1:0]        nch_eff;
    logic signed [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0]        sum_mag;
    logic                    accept;
    logic                    frame_last;
    logic [DIV_W:0]          trial;
    logic [DIV_W:0]          trial_sub;
    logic                    fits;
    logic [SAMPLE_W-1:0]     q16;

    // zero channels means one, anything above the build limit is clamped
    always_comb
    begin
        if (num_channels == '0)
        begin
            nch_eff = DIV_W'(1);
        end
        else if (int'(num_channels) > MAX_CHANNELS)
        begin
            nch_eff = DIV_W'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = DIV_W'(num_channels);
        end
    end

    assign full       = (state_reg != F_TAKE);
    assign accept     = push && !full;
    assign sum_add    = frame_sum_reg + SUM_W'(capture_sample);
    assign sum_mag    = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    // a lowered count mid-frame closes the frame on this sample
    assign frame_last = (int'(pos_reg) + 1) >= int'(nch_eff);

    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    assign q16        = quo_reg[SAMPLE_W-1:0];
    assign mono_value = sign_reg ? (-q16) : q16;
    assign mono_push  = (state_reg == F_HOLD) && !mono_full;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        frame_sum_next = frame_sum_reg;
        bit_cnt_next   = bit_cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        sign_next      = sign_reg;
        case (state_reg)
            F_TAKE:
            begin
                if (accept)
                begin
                    if (frame_last)
                    begin
                        pos_next       = '0;
                        frame_sum_next = '0;
                        quo_next       = sum_mag;
                        rem_next       = '0;
                        div_next       = nch_eff;
                        sign_next      = sum_add[SUM_W-1];
                        bit_cnt_next   = BIT_W'(SUM_W);
                        state_next     = F_DIV;
                    end
                    else
                    begin
                        pos_next       = pos_reg + CH_W'(1);
                        frame_sum_next = sum_add;
                    end
                end
            end
            F_DIV:
            begin
                rem_next     = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_next     = {quo_reg[SUM_W-2:0], fits};
                bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(1))
                begin
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (mono_push)
                begin
                    state_next = F_TAKE;
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_TAKE;
            pos_reg       <= '0;
            frame_sum_reg <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            frame_sum_reg <= frame_sum_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        sign_reg <= sign_next;
    end

endmodule

[hw/rtl/adlr_back.sv]
// ----------------------------------------------------------------------------
// adlr_back
// Linear interpolation between the previous and the new mono sample, driven
// by the phase accumulator, with chunk counting on the outputs.
// ----------------------------------------------------------------------------
module adlr_back
    import adlr_pkg::*;
#(
    parameter int PHASE_FRACTION_BITS = 16,
    parameter int MAX_CHUNK           = 4096,
    parameter int STEP_W              = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STEP_W-1:0]   phase_step,
    input  logic [CLEN_W-1:0]   chunk_length,
    input  logic                mono_empty,
    input  logic [SAMPLE_W-1:0] mono_value,
    output logic                mono_pop,
    input  logic                res_full,
    output logic                res_push,
    output result_t             res
);

    localparam int PFB    = PHASE_FRACTION_BITS;
    localparam int PH_W   = PFB + 4;
    localparam int ADD_W  = ((STEP_W > PH_W) ? STEP_W : PH_W) + 1;
    localparam int PROD_W = PFB + 18;
    localparam int MIX_W  = PFB + 19;
    localparam int FILL_W = $clog2(MAX_CHUNK);
    localparam int CL_W   = ($clog2(MAX_CHUNK + 1) > CLEN_W) ? $clog2(MAX_CHUNK + 1) : CLEN_W;
    localparam logic [MIX_W-1:0] ROUND_HALF = MIX_W'(1) << (PFB - 1);
    localparam logic [PH_W-1:0]  PHASE_ONE  = PH_W'(1) << PFB;

    typedef enum logic [3:0]
    {
        B_IDLE = 4'b0001,
        B_MULT = 4'b0010,
        B_EMIT = 4'b0100,
        B_WRAP = 4'b1000
    } back_state_t;

    back_state_t                state_reg, state_next;
    logic [SAMPLE_W-1:0]        prev_reg, prev_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic [SAMPLE_W-1:0]        cur_reg, cur_next;
    logic signed [SAMPLE_W:0]   diff_reg, diff_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [PH_W-1:0]            phase_reg, phase_next;
    logic [OUT_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;

    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PFB:0]        frac_s;
    logic signed [MIX_W-1:0]    mix;
    logic [ADD_W-1:0]           step_sum;
    logic [PH_W-1:0]            phase_adv;
    logic                       below_one;
    logic                       adv_below;
    logic [CL_W-1:0]            clen_eff;
    logic                       end_now;

    always_comb
    begin
        if (chunk_length == '0)
        begin
            clen_eff = CL_W'(1);
        end
        else if (CL_W'(chunk_length) > CL_W'(MAX_CHUNK))
        begin
            clen_eff = CL_W'(MAX_CHUNK);
        end
        else
        begin
            clen_eff = CL_W'(chunk_length);
        end
    end

    assign below_one = (phase_reg[PH_W-1:PFB] == '0);
    assign frac_s    = $signed({1'b0, phase_reg[PFB-1:0]});
    assign prod_next = diff_reg * frac_s;

    // prev*(1-a) + new*a == prev + (new-prev)*a, floor after adding a half
    assign mix = MIX_W'($signed({prev_reg, {PFB{1'b0}}})) + MIX_W'(prod_reg)
               + $signed(ROUND_HALF);

    // saturate at all ones rather than wrap
    assign step_sum  = ADD_W'(phase_reg) + ADD_W'(phase_step);
    assign phase_adv = (|step_sum[ADD_W-1:PH_W]) ? '1 : step_sum[PH_W-1:0];
    assign adv_below = (phase_adv[PH_W-1:PFB] == '0);

    // a lowered length mid-chunk ends the chunk on the next output
    assign end_now = (CL_W'(fill_reg) + CL_W'(1)) >= clen_eff;

    assign mono_pop      = (state_reg == B_IDLE) && !mono_empty;
    assign res_push      = (state_reg == B_EMIT) && !res_full;
    assign res.value     = mix[PFB+SAMPLE_W-1:PFB];
    assign res.chunk_end = end_now;

    always_comb
    begin
        state_next      = state_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        cur_next        = cur_reg;
        diff_next       = diff_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (mono_pop)
                begin
                    if (!prev_valid_reg)
                    begin
                        // first sample is only stored
                        prev_next       = mono_value;
                        prev_valid_next = 1'b1;
                    end
                    else
                    begin
                        cur_next   = mono_value;
                        diff_next  = $signed({mono_value[SAMPLE_W-1], mono_value})
                                   - $signed({prev_reg[SAMPLE_W-1], prev_reg});
                        cnt_next   = '0;
                        state_next = below_one ? B_MULT : B_WRAP;
                    end
                end
            end
            B_MULT:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (res_push)
                begin
                    fill_next  = end_now ? '0 : fill_reg + FILL_W'(1);
                    cnt_next   = cnt_reg + OUT_CNT_W'(1);
                    phase_next = phase_adv;
                    if (adv_below && (int'(cnt_reg) + 1 < MAX_OUT))
                    begin
                        state_next = B_MULT;
                    end
                    else
                    begin
                        state_next = B_WRAP;
                    end
                end
            end
            B_WRAP:
            begin
                // still below one here only when the output cap stopped the run
                phase_next = below_one ? '0 : phase_reg - PHASE_ONE;
                prev_next  = cur_reg;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
    end

endmodule

[hw/rtl/audio_downmix_linear_resampler.sv]
// ----------------------------------------------------------------------------
// audio_downmix_linear_resampler
// Interleaved capture samples in, mono samples at the target rate out:
// each frame of num_channels samples is averaged (truncating towards zero)
// and the mono stream is resampled by linear interpolation under a phase
// accumulator advanced by phase_step, rounding half up; chunk_end marks
// the last output of every chunk_length outputs. A sample that does not
// close a frame is taken without holding off push. Closing a frame starts
// the front-end divider, which retires one quotient bit a cycle, and push
// is held off until its result enters the mono queue. The back end visits
// B_MULT and B_EMIT for each output, between B_IDLE and B_WRAP, and makes
// at most sixteen outputs for one mono sample. A two-entry queue between
// the two lets the divider work on the next frame while outputs are made,
// and a four-entry result queue holds outputs while pop is low.
// ----------------------------------------------------------------------------
module audio_downmix_linear_resampler
    import adlr_pkg::*;
#(
    parameter int MAX_CHANNELS        = 8,
    parameter int MAX_CHUNK           = 4096,
    parameter int PHASE_FRACTION_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic signed [SAMPLE_W-1:0] capture_sample,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] resampled_value,
    output logic                       chunk_end
);

    localparam int STEP_W = (PHASE_FRACTION_BITS + 1 > STEP_CFG_W)
                          ? PHASE_FRACTION_BITS + 1 : STEP_CFG_W;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << PHASE_FRACTION_BITS;

    logic [NCH_W-1:0]    nch_reg, nch_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CLEN_W-1:0]   clen_reg, clen_next;

    logic                mono_push;
    logic                mono_full;
    logic [SAMPLE_W-1:0] mono_wr_data;
    logic                mono_pop;
    logic                mono_empty;
    logic [SAMPLE_W-1:0] mono_rd_data;
    logic                res_push;
    logic                res_full;
    result_t             res_wr;
    result_t             res_rd;

    always_comb
    begin
        nch_next  = nch_reg;
        step_next = step_reg;
        clen_next = clen_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_CHANNELS: nch_next  = cfg_data[NCH_W-1:0];
                REG_PHASE_STEP:   step_next = STEP_W'(cfg_data[STEP_CFG_W-1:0]);
                REG_CHUNK_LENGTH: clen_next = cfg_data[CLEN_W-1:0];
                default:          nch_next  = nch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg  <= NCH_RESET;
            step_reg <= STEP_RESET;
            clen_reg <= CLEN_RESET;
        end
        else
        begin
            nch_reg  <= nch_next;
            step_reg <= step_next;
            clen_reg <= clen_next;
        end
    end

    adlr_front
    #(
        .MAX_CHANNELS (MAX_CHANNELS)
    )
    u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .num_channels   (nch_reg),
        .push           (push),
        .full           (full),
        .capture_sample (capture_sample),
        .mono_push      (mono_push),
        .mono_full      (mono_full),
        .mono_value     (mono_wr_data)
    );

    adlr_fifo
    #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2)
    )
    u_mono_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mono_push),
        .wr_data (mono_wr_data),
        .full    (mono_full),
        .rd_en   (mono_pop),
        .rd_data (mono_rd_data),
        .empty   (mono_empty)
    );

    adlr_back
    #(
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS),
        .MAX_CHUNK           (MAX_CHUNK),
        .STEP_W              (STEP_W)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .phase_step   (step_reg),
        .chunk_length (clen_reg),
        .mono_empty   (mono_empty),
        .mono_value   (mono_rd_data),
        .mono_pop     (mono_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res_wr)
    );

    adlr_fifo
    #(
        .WIDTH ($bits(result_t)),
        .DEPTH (4)
    )
    u_res_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign resampled_value = $signed(res_rd.value);
    assign chunk_end       = res_rd.chunk_end;

endmodule

[dv/adlr_output_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adlr_output_checker
// Watches the configuration, sample and result ports of the downmix
// resampler, keeps its own copy of the downmix, phase and chunk state, and
// compares every popped result against the oldest predicted output.
// ----------------------------------------------------------------------------
module adlr_output_checker
    import adlr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       push,
    input  logic                       full,
    input  logic signed [SAMPLE_W-1:0] capture_sample,
    input  logic                       empty,
    input  logic                       pop,
    input  logic signed [SAMPLE_W-1:0] resampled_value,
    input  logic                       chunk_end,
    output int                         owed,
    output int                         fault_count
);

    localparam int     FRAC_BITS    = 16;
    localparam int     MAX_CHANNELS = 8;
    localparam int     MAX_CHUNK    = 4096;
    localparam longint PHASE_ONE    = longint'(1) << FRAC_BITS;
    localparam longint PHASE_MAX    = (longint'(1) << (FRAC_BITS + 4)) - 1;

    logic [NCH_W-1:0]          nch_reg;
    logic [STEP_CFG_W-1:0]     ratio_reg;
    logic [CLEN_W-1:0]         clen_reg;

    int                        frame_pos;
    int                        frame_acc;
    logic signed [SAMPLE_W-1:0] prev_mono;
    bit                        prev_ok;
    longint                    phase;
    int                        fill;

    result_t                   predicted_outputs[$];
    result_t                   oldest;
    int                        errs = 0;

    // rounded half up; the bias keeps the sum nonnegative before the shift
    function automatic logic [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] older,
                                                  input logic signed [SAMPLE_W-1:0] newer,
                                                  input longint frac);
        longint mix;
        longint biased;
        mix    = longint'(older) * (PHASE_ONE - frac) + longint'(newer) * frac;
        biased = mix + 32768 * PHASE_ONE + PHASE_ONE / 2;
        return SAMPLE_W'((biased >>> FRAC_BITS) - 32768);
    endfunction

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        int      nch;
        int      lim;
        int      mono;
        int      made;
        result_t r;
        nch = nch_reg;
        if (nch == 0)
            nch = 1;
        if (nch > MAX_CHANNELS)
            nch = MAX_CHANNELS;
        lim = clen_reg;
        if (lim == 0)
            lim = 1;
        if (lim > MAX_CHUNK)
            lim = MAX_CHUNK;

        frame_acc += int'(s);
        if (frame_pos + 1 < nch)
        begin
            frame_pos++;
            return;
        end
        mono      = frame_acc / nch;
        frame_acc = 0;
        frame_pos = 0;

        if (!prev_ok)
        begin
            prev_mono = SAMPLE_W'(mono);
            prev_ok   = 1'b1;
            return;
        end

        made = 0;
        while (phase < PHASE_ONE && made < MAX_OUT)
        begin
            r.value = blend(prev_mono, SAMPLE_W'(mono), phase);
            if (fill + 1 >= lim)
            begin
                r.chunk_end = 1'b1;
                fill        = 0;
            end
            else
            begin
                r.chunk_end = 1'b0;
                fill++;
            end
            predicted_outputs.push_back(r);
            made++;
            phase += longint'(ratio_reg);
            if (phase > PHASE_MAX)
                phase = PHASE_MAX;
        end

        // capped with phase still below one: restart from zero
        if (phase >= PHASE_ONE)
            phase -= PHASE_ONE;
        else
            phase = 0;
        prev_mono = SAMPLE_W'(mono);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg   = NCH_RESET;
            ratio_reg = STEP_CFG_W'(PHASE_ONE);
            clen_reg  = CLEN_RESET;
            frame_pos = 0;
            frame_acc = 0;
            prev_mono = '0;
            prev_ok   = 1'b0;
            phase     = 0;
            fill      = 0;
            predicted_outputs.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_NUM_CHANNELS: nch_reg   = cfg_data[NCH_W-1:0];
                    REG_PHASE_STEP:   ratio_reg = cfg_data[STEP_CFG_W-1:0];
                    REG_CHUNK_LENGTH: clen_reg  = cfg_data[CLEN_W-1:0];
                    default: ;
                endcase
            end

            // results leaving this edge were made from earlier requests
            if (pop && !empty)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result: expected none, got %0d/%0b",
                             $time, resampled_value, chunk_end);
                end
                else
                begin
                    oldest = predicted_outputs.pop_front();
                    if (oldest.value !== resampled_value || oldest.chunk_end !== chunk_end)
                    begin
                        errs++;
                        $display("%0t: value/chunk_end expected %0d/%0b, got %0d/%0b",
                                 $time, $signed(oldest.value), oldest.chunk_end,
                                 resampled_value, chunk_end);
                    end
                end
            end

            if (push && !full)
                take_sample(capture_sample);
        end
        owed        <= predicted_outputs.size();
        fault_count <= errs;
    end

endmodule

[dv/audio_downmix_linear_resampler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_downmix_linear_resampler_tb
// Drives capture samples in bursts under several register settings, with a
// directed opening over the clamps, skips and the output cap, then random
// phases; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module audio_downmix_linear_resampler_tb;
    import adlr_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 500;
    localparam int RANDOM_ITEMS  = 280;

    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;
    logic                       push           = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] capture_sample = '0;
    logic                       empty;
    logic                       pop            = 1'b0;
    logic signed [SAMPLE_W-1:0] resampled_value;
    logic                       chunk_end;

    int owed;
    int fault_count;
    int burst_left = 0;
    int quiet      = 0;
    bit choke_req  = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    audio_downmix_linear_resampler DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .capture_sample (capture_sample),
        .empty          (empty),
        .pop            (pop),
        .resampled_value(resampled_value),
        .chunk_end      (chunk_end)
    );

    adlr_output_checker output_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .capture_sample (capture_sample),
        .empty          (empty),
        .pop            (pop),
        .resampled_value(resampled_value),
        .chunk_end      (chunk_end),
        .owed           (owed),
        .fault_count    (fault_count)
    );

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // unused high data bits are filled at random
    task automatic program_regs(input logic [3:0] which, input int nch, input int ratio,
                                input int clen);
        logic [CFG_DATA_W-1:0] d;
        if (which[REG_NUM_CHANNELS])
        begin
            d = CFG_DATA_W'($urandom);
            d[NCH_W-1:0] = NCH_W'(nch);
            write_one(REG_NUM_CHANNELS, d);
        end
        if (which[REG_PHASE_STEP])
            write_one(REG_PHASE_STEP, CFG_DATA_W'(ratio));
        if (which[REG_CHUNK_LENGTH])
        begin
            d = CFG_DATA_W'($urandom);
            d[CLEN_W-1:0] = CLEN_W'(clen);
            write_one(REG_CHUNK_LENGTH, d);
        end
        if (which[REG_SPARE])
            write_one(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(16, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push           <= 1'b1;
        capture_sample <= s;
        do
            @(posedge clk);
        while (full);
    endtask

    // waits for an edge first so the count includes the request just taken
    task automatic drain_and_wait();
        push <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel == 0)
            return ($urandom_range(1, 0) != 0) ? 16'sh7FFF : 16'sh8000;
        if (sel == 1)
            return SAMPLE_W'(int'($urandom_range(64, 0)) - 32);
        return SAMPLE_W'($urandom);
    endfunction

    // frame size for rounding the item count; zero if the count was not rewritten
    function automatic int output_nch(input logic [3:0] which, input int nch);
        if (!which[REG_NUM_CHANNELS])
            return 0;
        if (nch == 0)
            return 1;
        return (nch > 8) ? 8 : nch;
    endfunction

    initial
    begin : stimulus
        int rand_sent;
        int nch;
        int eff;
        int ratio;
        int clen;
        int n;
        int sel;
        logic [3:0] which;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero channels and zero chunk length clamp to one; zero step hits the cap
        program_regs(4'b1111, 0, 0, 0);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_and_wait();

        // three channels, truncation towards zero, then a partial frame
        program_regs(4'b0111, 3, 20000, 5);
        send_sample(-16'sd1);
        send_sample(-16'sd2);
        send_sample(16'sd2);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8001);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        drain_and_wait();

        // channel count and chunk length lowered mid-frame and mid-chunk
        program_regs(4'b0101, 2, 0, 2);
        send_sample(16'sd7);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        drain_and_wait();

        // step above one: source samples skipped
        program_regs(4'b0111, 1, 32'h18000, 4096);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        drain_and_wait();

        // eight and fifteen channels clamp alike; saturating step
        program_regs(4'b0111, 15, 32'hFFFFF, 8191);
        repeat (8) send_sample(16'sh8000);
        drain_and_wait();

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(9, 0);
            if (sel == 0)
                nch = 0;
            else if (sel == 1)
                nch = $urandom_range(15, 9);
            else
                nch = $urandom_range(8, 1);

            sel = $urandom_range(9, 0);
            if (sel == 0)
                ratio = $urandom_range(4095, 0);
            else if (sel == 1)
                ratio = $urandom_range(32'hFFFFF, 786433);
            else if (sel == 2)
                ratio = ($urandom_range(1, 0) != 0) ? 4096 : 786432;
            else
                ratio = $urandom_range(200000, 4096);

            sel = $urandom_range(9, 0);
            if (sel == 0)
                clen = 0;
            else if (sel == 1)
                clen = $urandom_range(8191, 4096);
            else
                clen = $urandom_range(40, 1);

            which = 4'($urandom_range(7, 1));
            if ($urandom_range(7, 0) == 0)
                which[REG_SPARE] = 1'b1;
            n = $urandom_range(48, 8);

            if (rand_sent == 0)
            begin
                // steady output flow while the receiver holds off
                which = 4'b0111;
                nch   = 1;
                ratio = $urandom_range(65536, 16384);
                n     = 48;
                choke_req = 1'b1;
            end
            program_regs(which, nch, ratio, clen);

            eff = output_nch(which, nch);
            if (eff > 0 && $urandom_range(3, 0) != 0)
                n = ((n + eff - 1) / eff) * eff;
            repeat (n)
            begin
                send_sample(pick_sample());
                rand_sent++;
            end
            drain_and_wait();
        end

        if (fault_count == 0 && owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : receiver
        int tick;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (choke_req)
            begin
                choke_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                tick++;
                case ((tick / 50) % 4)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(99, 0) < 50);
                    2:       pop <= (tick % 3 == 0);
                    default: pop <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet <= 0;
        else if (quiet >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule

[sim.f]
hw/rtl/adlr_pkg.sv
hw/rtl/adlr_fifo.sv
hw/rtl/adlr_front.sv
hw/rtl/adlr_back.sv
hw/rtl/audio_downmix_linear_resampler.sv
dv/adlr_output_checker.sv
dv/audio_downmix_linear_resampler_tb.sv
